// ===== hw/rtl/cw_envelope_agc_threshold_detector_defines.svh =====
// assertion macros shared by the cw envelope agc detector rtl
// expects clk_i and rst_ni in the scope of each use
`ifndef CW_ENVELOPE_AGC_THRESHOLD_DETECTOR_DEFINES_SVH
`define CW_ENVELOPE_AGC_THRESHOLD_DETECTOR_DEFINES_SVH

// property must hold at every clock edge outside reset
`define CWAGC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// expression must never be true outside reset
`define CWAGC_NEVER(name, expr, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error(msg);

`endif

// ===== hw/rtl/cwagc_pkg.sv =====
// types, constants and helper functions of the cw envelope agc detector
// no dependencies
package cwagc_pkg;

  localparam int ENV_BITS        = 16;
  localparam int TRACK_FRAC_BITS = 24;
  localparam int GAIN_BITS       = 16;
  localparam int TIME_BITS       = 32;
  localparam int CFG_IDX_BITS    = 1;

  localparam logic [GAIN_BITS-1:0] ATTACK_GAIN_RST = 16'd328;
  localparam logic [GAIN_BITS-1:0] DECAY_GAIN_RST  = 16'd66;

  localparam logic [ENV_BITS-1:0] ENV_MAX = {ENV_BITS{1'b1}};

  // pre-divide level value: below five times the envelope range, or saturated
  localparam int LVL_W = ENV_BITS + 3;
  localparam logic [LVL_W-1:0] LEVEL_SAT = LVL_W'(5) << ENV_BITS;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_ATTACK_GAIN = 1'b0,
    REG_DECAY_GAIN  = 1'b1
  } cwagc_reg_e;

  typedef struct packed {
    logic [ENV_BITS-1:0]  envelope;
    logic                 in_tone;
    logic [TIME_BITS-1:0] sample_time;
  } cwagc_in_t;

  typedef struct packed {
    logic                 key_down;
    logic                 key_up;
    logic [TIME_BITS-1:0] event_time;
    logic [ENV_BITS-1:0]  upper_level;
    logic [ENV_BITS-1:0]  lower_level;
    logic [ENV_BITS-1:0]  peak_level;
  } cwagc_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_AVG_MUL,
    ST_AVG_UPD,
    ST_FP_MUL,
    ST_FP_UPD,
    ST_SUM,
    ST_LO,
    ST_DIV_UP,
    ST_DIV_LO
  } cwagc_state_e;

  typedef struct packed {
    logic busy;
    logic take;
    logic avg_mul;
    logic avg_upd;
    logic fp_mul;
    logic fp_upd;
    logic sum;
    logic lo;
    logic div_up;
    logic emit;
  } cwagc_ctrl_t;

  // exact unsigned divide by five, shift-add estimate plus remainder fixup
  function automatic logic [31:0] div5(input logic [31:0] n);
    logic [31:0] q;
    logic [31:0] r;
    q = (n >> 1) + (n >> 2);
    q = q + (q >> 4);
    q = q + (q >> 8);
    q = q + (q >> 16);
    q = q >> 2;
    r = n - ((q << 2) + q);
    return q + (((r << 3) - r) >> 5);
  endfunction

  // rounded level value to envelope units, saturated
  function automatic logic [ENV_BITS-1:0] level_of(input logic [LVL_W-1:0] m);
    logic [31:0] q;
    q = div5(32'(m));
    return (m >= LEVEL_SAT) ? ENV_MAX : q[ENV_BITS-1:0];
  endfunction

endpackage

// ===== hw/rtl/cwagc_track.sv =====
// shared tracking unit: x moves toward v by |v - x| * gain / 65536, rounded
// multiply and round into a register, then add or subtract combinationally; uses cwagc_pkg
`include "cw_envelope_agc_threshold_detector_defines.svh"

module cwagc_track #(
  parameter int STATE_BITS = cwagc_pkg::TRACK_FRAC_BITS + 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           mul_en_i,
  input  logic [STATE_BITS-1:0]          x_i,
  input  logic [STATE_BITS-1:0]          v_i,
  input  logic [cwagc_pkg::GAIN_BITS-1:0] gain_i,
  output logic [STATE_BITS-1:0]          y_o
);
  import cwagc_pkg::*;

  localparam int PW = STATE_BITS + GAIN_BITS;
  localparam logic [PW-1:0] ROUND_HALF = PW'(1) << (GAIN_BITS - 1);

  logic                  rise_d, rise_q;
  logic [STATE_BITS-1:0] diff;
  logic [STATE_BITS-1:0] x_q;
  logic [STATE_BITS-1:0] step;
  logic [PW-1:0]         prod_d, prod_q;

  always_comb begin
    rise_d = v_i >= x_i;
    diff   = rise_d ? (v_i - x_i) : (x_i - v_i);
    prod_d = PW'(diff) * PW'(gain_i) + ROUND_HALF;
  end

  always_ff @(posedge clk_i) begin
    if (mul_en_i) begin
      prod_q <= prod_d;
      x_q    <= x_i;
      rise_q <= rise_d;
    end
  end

  // step never exceeds the distance, so no wrap
  assign step = prod_q[PW-1:GAIN_BITS];
  assign y_o  = rise_q ? (x_q + step) : (x_q - step);

  `CWAGC_ASSERT(a_step_no_overshoot, $past(mul_en_i) |-> (rise_q ? (y_o >= x_q && y_o <= v_i) : (y_o <= x_q && y_o >= v_i)), "tracking step overshoots the sample")

endmodule

// ===== hw/rtl/cwagc_seq.sv =====
// sequencer of the cw envelope agc detector, one word at a time
// drives the per-state control strobes; uses cwagc_pkg
`include "cw_envelope_agc_threshold_detector_defines.svh"

module cwagc_seq (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   out_free_i,
  output cwagc_pkg::cwagc_ctrl_t ctrl_o
);
  import cwagc_pkg::*;

  cwagc_state_e state_d, state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    ctrl_o      = '0;
    ctrl_o.busy = state_q != ST_IDLE;
    case (state_q)
      ST_IDLE: begin
        ctrl_o.take = in_valid_i;
        if (in_valid_i) state_d = ST_AVG_MUL;
      end
      ST_AVG_MUL: begin
        ctrl_o.avg_mul = 1'b1;
        state_d        = ST_AVG_UPD;
      end
      ST_AVG_UPD: begin
        ctrl_o.avg_upd = 1'b1;
        state_d        = ST_FP_MUL;
      end
      ST_FP_MUL: begin
        ctrl_o.fp_mul = 1'b1;
        state_d       = ST_FP_UPD;
      end
      ST_FP_UPD: begin
        ctrl_o.fp_upd = 1'b1;
        state_d       = ST_SUM;
      end
      ST_SUM: begin
        ctrl_o.sum = 1'b1;
        state_d    = ST_LO;
      end
      ST_LO: begin
        ctrl_o.lo = 1'b1;
        state_d   = ST_DIV_UP;
      end
      ST_DIV_UP: begin
        ctrl_o.div_up = 1'b1;
        state_d       = ST_DIV_LO;
      end
      ST_DIV_LO: begin
        // wait here while the previous word still sits in the output register
        ctrl_o.emit = out_free_i;
        if (out_free_i) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  `CWAGC_ASSERT(a_hold_when_blocked, (state_q == ST_DIV_LO && !out_free_i) |=> state_q == ST_DIV_LO, "result dropped while output register full")
  `CWAGC_ASSERT(a_take_starts_work, ctrl_o.take |=> ctrl_o.avg_mul, "accepted word did not start the sequence")

endmodule

// ===== hw/rtl/cw_envelope_agc_threshold_detector.sv =====
// a word taken runs through the sequencer states, then is registered on the
// output; no new word is taken until the sequencer is idle; under it the single
//   shared tracking multiplier is used twice per word (average, then floor or peak)
// reset: gains back to defaults, average 0, floor and peak 1.0, output empty
// no clearing pass after reset; uses cwagc_pkg, cwagc_seq, cwagc_track
`include "cw_envelope_agc_threshold_detector_defines.svh"

module cw_envelope_agc_threshold_detector #(
  parameter int TRACK_FRACTION_BITS = cwagc_pkg::TRACK_FRAC_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [cwagc_pkg::CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [cwagc_pkg::GAIN_BITS-1:0]    cfg_data_i,
  input  logic                              in_valid_i,
  input  cwagc_pkg::cwagc_in_t              in_data_i,
  output logic                              in_stall_o,
  output logic                              out_valid_o,
  output cwagc_pkg::cwagc_out_t             out_data_o,
  input  logic                              out_stall_i
);
  import cwagc_pkg::*;

  localparam int SW     = TRACK_FRACTION_BITS + 8;
  localparam int ALIGN  = TRACK_FRACTION_BITS - (ENV_BITS - 8);
  localparam int UPW    = SW + 3;
  localparam int LOSUMW = SW + 4;

  localparam logic [SW-1:0]     STATE_ONE = SW'(1) << TRACK_FRACTION_BITS;
  localparam logic [UPW-1:0]    HALF_UP   = (UPW'(5) << ALIGN) >> 1;
  localparam logic [LOSUMW-1:0] HALF_LO   = LOSUMW'(5) << ALIGN;
  localparam logic [SW:0]       HALF_PK   = ((SW + 1)'(1) << ALIGN) >> 1;

  cwagc_ctrl_t ctrl;

  logic [GAIN_BITS-1:0] atk_q, dcy_q;
  logic [SW-1:0]        avg_q, floor_q, peak_q;

  logic [ENV_BITS-1:0]  env_q;
  logic                 tone_q;
  logic [TIME_BITS-1:0] time_q;
  logic                 upd_floor_q, upd_peak_q;
  logic [UPW-1:0]       up_q;
  logic [LOSUMW-1:0]    lo_q;
  logic [LVL_W-1:0]     m_q;
  logic                 kd_q, ku_q;
  logic [ENV_BITS-1:0]  uplvl_q, pklvl_q;

  logic                 out_valid_q;
  cwagc_out_t           out_data_d, out_data_q;
  logic                 out_free;

  logic [SW-1:0]        v;
  logic [UPW-1:0]       v5;
  logic [LOSUMW-1:0]    v10;
  logic [SW-1:0]        trk_x, trk_y;
  logic [GAIN_BITS-1:0] trk_gain;
  logic [UPW-1:0]       up_d;
  logic [LOSUMW-1:0]    lo_d;
  logic [UPW-1:0]       up_round;
  logic [LOSUMW-1:0]    lo_round;
  logic [SW:0]          pk_round, pk_shift;
  logic [ENV_BITS-1:0]  pklvl_d;
  logic                 live;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = ctrl.busy;

  cwagc_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_free_i (out_free),
    .ctrl_o     (ctrl)
  );

  // sample aligned to the tracking format
  assign v   = SW'(env_q) << ALIGN;
  assign v5  = (UPW'(v) << 2) + UPW'(v);
  assign v10 = LOSUMW'(v5) << 1;

  // pick operands of the shared tracking unit
  always_comb begin
    trk_x    = avg_q;
    trk_gain = dcy_q;
    if (ctrl.fp_mul) begin
      if (v < avg_q) begin
        trk_x    = floor_q;
        trk_gain = (v < floor_q) ? atk_q : dcy_q;
      end else begin
        trk_x    = peak_q;
        trk_gain = (v > peak_q) ? atk_q : dcy_q;
      end
    end
  end

  cwagc_track #(
    .STATE_BITS (SW)
  ) u_track (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .mul_en_i (ctrl.avg_mul | ctrl.fp_mul),
    .x_i      (trk_x),
    .v_i      (v),
    .gain_i   (trk_gain),
    .y_o      (trk_y)
  );

  // thresholds: up_q is 5x upper, lo_q is 10x lower
  always_comb begin
    up_d     = (UPW'(avg_q) << 2) + UPW'(floor_q);
    lo_d     = (LOSUMW'(up_q) << 1) + LOSUMW'(floor_q) - LOSUMW'(avg_q);
    up_round = up_q + HALF_UP;
    lo_round = lo_q + HALF_LO;
    pk_round = (SW + 1)'(peak_q) + HALF_PK;
    pk_shift = pk_round >> ALIGN;
    pklvl_d  = (|pk_shift[SW:ENV_BITS]) ? ENV_MAX : pk_shift[ENV_BITS-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      atk_q   <= ATTACK_GAIN_RST;
      dcy_q   <= DECAY_GAIN_RST;
      avg_q   <= '0;
      floor_q <= STATE_ONE;
      peak_q  <= STATE_ONE;
    end else begin
      if (cfg_we_i) begin
        case (cwagc_reg_e'(cfg_idx_i))
          REG_ATTACK_GAIN: atk_q <= cfg_data_i;
          REG_DECAY_GAIN:  dcy_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if (ctrl.avg_upd) avg_q <= trk_y;
      if (ctrl.fp_upd && upd_floor_q) floor_q <= trk_y;
      if (ctrl.fp_upd && upd_peak_q) peak_q <= trk_y;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.take) begin
      env_q  <= in_data_i.envelope;
      tone_q <= in_data_i.in_tone;
      time_q <= in_data_i.sample_time;
    end
    if (ctrl.fp_mul) begin
      upd_floor_q <= v < avg_q;
      upd_peak_q  <= v > avg_q;
    end
    if (ctrl.sum) begin
      up_q    <= up_d;
      pklvl_q <= pklvl_d;
    end
    if (ctrl.lo) begin
      lo_q <= lo_d;
      kd_q <= v5 > up_q;
      m_q  <= LVL_W'(up_round >> ALIGN);
    end
    // m_q is reused: upper level value first, then lower
    if (ctrl.div_up) begin
      uplvl_q <= level_of(m_q);
      ku_q    <= v10 < lo_q;
      m_q     <= LVL_W'(lo_round >> (ALIGN + 1));
    end
  end

  assign live = peak_q != '0;

  always_comb begin
    out_data_d             = '0;
    out_data_d.key_down    = live && !tone_q && kd_q;
    out_data_d.key_up      = live && tone_q && ku_q;
    out_data_d.event_time  = time_q;
    out_data_d.upper_level = live ? uplvl_q : '0;
    out_data_d.lower_level = live ? level_of(m_q) : '0;
    out_data_d.peak_level  = pklvl_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.emit) out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `CWAGC_NEVER(a_keys_exclusive, out_valid_o && out_data_o.key_down && out_data_o.key_up, "key down and key up in one word")
  `CWAGC_ASSERT(a_valid_from_emit, $rose(out_valid_o) |-> $past(ctrl.emit), "output valid without a finished word")

endmodule
